// ----- sv/kmp_pkg.sv -----
// Shared constants, types and command codes for the KMP pattern match counter.
package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = 32;

  localparam int IN_DATA_W   = 8;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 40;

  localparam int OUT_HIT_BIT = 0;
  localparam int OUT_CNT_LSB = 1;
  localparam int OUT_CNT_MSB = OUT_CNT_LSB + CNT_W - 1;
  localparam int OUT_OVF_BIT = OUT_CNT_MSB + 1;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_OVF_BIT - 1;

  typedef enum logic [IN_USER_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2
  } func_t;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic clr_act;
    logic text_step;
    logic wr_en;
    logic in_use;
    logic is_last;
  } cell_ctrl_t;

endpackage

// ----- sv/kmp_pattern_match_counter_top.sv -----
// Top level: command decode, row of matcher cells, saturating count, output register.
// Each result is registered and appears on the output in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; every cell compares its byte in parallel and
// hands its partial-match bit to the next cell, so no failure-link walk is needed.
// Reset clears the pattern length, all partial matches, the count and the output
// valid; pattern bytes are not cleared and are only read below the pattern length.
module kmp_pattern_match_counter_top import kmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] char_value
  input  logic [IN_USER_W-1:0]  in_tuser,   // [1:0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] match_found, [32:1] match_count,
                                            // [33] pattern_overflow, [39:34] zero
);

  logic                  in_acc;
  func_t                 func;
  logic                  cmd_clear;
  logic                  cmd_append;
  logic                  cmd_text;
  logic                  full;
  logic                  append_ok;

  len_t                  len_r;
  len_t                  len_nxt;
  cnt_t                  count_r;
  cnt_t                  count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  logic [MAX_PATTERN-1:0] act_vec;
  logic [MAX_PATTERN-1:0] hit_vec;
  logic                   hit_any;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign func      = func_t'(in_tuser);

  always_comb begin
    cmd_clear  = 1'b0;
    cmd_append = 1'b0;
    cmd_text   = 1'b0;
    case (func)
      FUNC_CLEAR:  cmd_clear  = in_acc;
      FUNC_APPEND: cmd_append = in_acc;
      FUNC_TEXT:   cmd_text   = in_acc;
      default: ;
    endcase
  end

  assign full      = (len_r == LEN_W'(MAX_PATTERN));
  assign append_ok = cmd_append & ~full;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic       prev_act;

    always_comb begin
      // a new pattern byte restarts matching from scratch
      ctrl.clr_act   = cmd_clear | append_ok;
      ctrl.text_step = cmd_text;
      ctrl.wr_en     = append_ok & (len_r == LEN_W'(i));
      ctrl.in_use    = (LEN_W'(i) < len_r);
      ctrl.is_last   = (LEN_W'(i + 1) == len_r);
    end

    if (i == 0) begin : g_head
      assign prev_act = 1'b1;
    end else begin : g_link
      assign prev_act = act_vec[i-1];
    end

    kmp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .char_in  (in_tdata[CHAR_W-1:0]),
      .prev_act (prev_act),
      .act      (act_vec[i]),
      .hit      (hit_vec[i])
    );
  end

  assign hit_any = |hit_vec;

  always_comb begin
    len_nxt = len_r;
    if (cmd_clear) begin
      len_nxt = '0;
    end else if (append_ok) begin
      len_nxt = len_r + LEN_W'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd_clear) begin
      count_nxt = '0;
    end else if (hit_any && (count_r != '1)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_data_nxt = {{OUT_PAD_W{1'b0}}, cmd_append & full, count_nxt, hit_any};
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/kmp_cell.sv -----
// One matcher cell: holds one pattern byte and the partial-match bit ending there.
module kmp_cell import kmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              prev_act,
  output logic              act,
  output logic              hit
);

  logic [CHAR_W-1:0] byte_r;
  logic              act_r;
  logic              act_nxt;
  logic              match_now;

  // prefix ending at the previous cell extends through this byte
  assign match_now = ctrl.in_use & prev_act & (byte_r == char_in);

  always_comb begin
    act_nxt = act_r;
    if (ctrl.clr_act) begin
      act_nxt = 1'b0;
    end else if (ctrl.text_step) begin
      act_nxt = match_now;
    end
  end

  assign hit = ctrl.text_step & ctrl.is_last & match_now;
  assign act = act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      byte_r <= char_in;
    end
  end

endmodule

// ----- sv/kmp_chk.sv -----
// Port-level checker for the KMP pattern match counter, bound to the top level.
module kmp_chk import kmp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid & in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == FUNC_CLEAR) |=> out_tvalid && (out_tdata == '0))
    else $error("clear request did not return a zero result");

  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_HIT_BIT] |-> out_tdata[OUT_CNT_MSB:OUT_CNT_LSB] != '0)
    else $error("match reported with zero count");

  a_ovf_append_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser != FUNC_APPEND) |=> !out_tdata[OUT_OVF_BIT])
    else $error("overflow flagged on a non-append request");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind kmp_pattern_match_counter_top kmp_chk u_kmp_chk (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the KMP pattern match counter: directed table, random runs.
module tb_top;
  import kmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_RSVD    = 2'd3;
  localparam int         RANDOM_ITEMS = 1250;
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic hit;
    cnt_t cnt;
    logic ovf;
  } match_result_t;

  typedef struct packed {
    logic [1:0]    func;
    logic [7:0]    ch;
    logic          typed;
    match_result_t res;
  } stim_row_t;

  localparam int DIRECTED_N = 25;

  // typed rows: after reset, clear, first pattern byte, first single-byte hit
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{FUNC_TEXT,   8'h41, 1'b1, '{1'b0, 32'd0, 1'b0}},  // empty pattern never matches
    '{FUNC_RSVD,   8'hFF, 1'b1, '{1'b0, 32'd0, 1'b0}},  // unused code: no change
    '{FUNC_APPEND, 8'h00, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{FUNC_TEXT,   8'h00, 1'b1, '{1'b1, 32'd1, 1'b0}},
    '{FUNC_TEXT,   8'hFF, 1'b0, '0},
    '{FUNC_TEXT,   8'h00, 1'b0, '0},
    '{FUNC_RSVD,   8'h00, 1'b0, '0},                    // count held on unused code
    '{FUNC_CLEAR,  8'hAA, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{FUNC_APPEND, 8'hAA, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{FUNC_APPEND, 8'hAA, 1'b0, '0},
    '{FUNC_TEXT,   8'hAA, 1'b0, '0},
    '{FUNC_TEXT,   8'hAA, 1'b0, '0},
    '{FUNC_TEXT,   8'hAA, 1'b0, '0},                    // overlapping hit
    '{FUNC_CLEAR,  8'h55, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{FUNC_APPEND, 8'h61, 1'b0, '0},
    '{FUNC_APPEND, 8'h62, 1'b0, '0},
    '{FUNC_APPEND, 8'h61, 1'b0, '0},
    '{FUNC_APPEND, 8'h62, 1'b0, '0},
    '{FUNC_TEXT,   8'h61, 1'b0, '0},
    '{FUNC_TEXT,   8'h62, 1'b0, '0},
    '{FUNC_TEXT,   8'h61, 1'b0, '0},
    '{FUNC_TEXT,   8'h62, 1'b0, '0},
    '{FUNC_TEXT,   8'h61, 1'b0, '0},
    '{FUNC_TEXT,   8'h62, 1'b0, '0},                    // hit through a failure link
    '{FUNC_APPEND, 8'h63, 1'b0, '0}                     // matcher restarts, count kept
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // matcher state tracked by the prediction function
  logic [CHAR_W-1:0] pat_store [MAX_PATTERN];
  logic [5:0]        fail_link [MAX_PATTERN];
  len_t              pat_len;
  logic [5:0]        border_len;
  len_t              match_pos;
  cnt_t              hit_count;

  match_result_t pending_matches [$];
  match_result_t rx_expected;
  int            error_count = 0;
  int            items_sent  = 0;
  int            cycle_count = 0;
  int            tx_idle_pct = 14;
  int            rx_idle_pct = 66;
  bit            hold_request = 1'b0;
  bit            hold_done    = 1'b0;

  kmp_pattern_match_counter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic match_result_t next_match_result(logic [1:0] func, logic [7:0] ch);
    match_result_t res;
    int            pos;
    int            k;
    int            j;
    res = '0;
    case (func)
      FUNC_CLEAR: begin
        pat_len    = '0;
        border_len = '0;
        match_pos  = '0;
        hit_count  = '0;
      end
      FUNC_APPEND: begin
        pos = int'(pat_len);
        if (pos >= MAX_PATTERN) begin
          res.ovf = 1'b1;
        end else begin
          pat_store[pos] = ch;
          if (pos == 0) begin
            fail_link[0] = '0;
            border_len   = '0;
          end else begin
            k = int'(border_len);
            if (k >= pos) k = 0;
            while (k > 0 && pat_store[pos] != pat_store[k]) k = int'(fail_link[k-1]);
            if (pat_store[pos] == pat_store[k]) k++;
            fail_link[pos] = 6'(k);
            border_len     = 6'(k);
          end
          pat_len   = len_t'(pos + 1);
          match_pos = '0;
        end
      end
      FUNC_TEXT: begin
        if (pat_len != 0) begin
          j = int'(match_pos);
          if (j >= int'(pat_len)) j = 0;
          while (j > 0 && pat_store[j] != ch) j = int'(fail_link[j-1]);
          if (pat_store[j] == ch) j++;
          if (j == int'(pat_len)) begin
            res.hit = 1'b1;
            if (hit_count != '1) hit_count = hit_count + cnt_t'(1);
            j = int'(fail_link[int'(pat_len) - 1]);
          end
          match_pos = len_t'(j);
        end
      end
      default: ;
    endcase
    res.cnt = hit_count;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s at cycle %0d: got %0h, want %0h", field, cycle_count, got, want);
    error_count++;
  endtask

  // offer one request, wait for the handshake, then queue its prediction
  task automatic send_request(logic [1:0] func, logic [7:0] ch, logic typed,
                              match_result_t typed_res);
    match_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = next_match_result(func, ch);
    pending_matches = {pending_matches, (typed ? typed_res : res)};
    items_sent++;
  endtask

  // often a clear, a pattern from a small alphabet, then text seeded with copies of it
  task automatic run_search();
    logic [7:0] alphabet [3];
    logic [7:0] pat [80];
    int         alpha_n;
    int         plen;
    int         tlen;
    int         i;
    int         k;
    int         pick;
    if ($urandom_range(9) < 8) send_request(FUNC_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
    alpha_n = $urandom_range(1, 3);
    for (i = 0; i < 3; i++) alphabet[i] = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) plen = $urandom_range(60, 70);
    else if ($urandom_range(15) == 0) plen = 0;
    else plen = $urandom_range(1, 5);
    for (i = 0; i < plen; i++) begin
      pat[i] = alphabet[$urandom_range(alpha_n - 1)];
      send_request(FUNC_APPEND, pat[i], 1'b0, '0);
    end
    tlen = $urandom_range(10, 40);
    i = 0;
    while (i < tlen) begin
      pick = $urandom_range(99);
      if (pick < 25 && plen > 0) begin
        for (k = 0; k < plen; k++) send_request(FUNC_TEXT, pat[k], 1'b0, '0);
        i += plen;
      end else begin
        if (pick < 28) send_request(FUNC_RSVD, 8'($urandom_range(255)), 1'b0, '0);
        else if (pick < 30) send_request(FUNC_APPEND, alphabet[0], 1'b0, '0);
        else if (pick < 31) send_request(FUNC_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
        else if (pick < 36) send_request(FUNC_TEXT, 8'($urandom_range(255)), 1'b0, '0);
        else send_request(FUNC_TEXT, alphabet[$urandom_range(alpha_n - 1)], 1'b0, '0);
        i++;
      end
    end
  endtask

  initial begin
    int r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_CLEAR;
    pat_len    = '0;
    border_len = '0;
    match_pos  = '0;
    hit_count  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIRECTED_N; r++)
      send_request(directed_rows[r].func, directed_rows[r].ch, directed_rows[r].typed,
                   directed_rows[r].res);

    while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 14;
        rx_idle_pct = 66;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 66;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // hold the output once while requests keep being offered
        if (!hold_done) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
        end
      end
      run_search();
    end
    in_tvalid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[kmp_pattern_match_counter_top] OK");
    end else begin
      $display("[kmp_pattern_match_counter_top] ERROR");
    end
    $finish;
  end

  initial begin
    int hold_cnt;
    bit hold_served;
    hold_served = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_tdata), 64'd0);
      end else begin
        rx_expected = pending_matches.pop_front();
        if (out_tdata[OUT_HIT_BIT] !== rx_expected.hit)
          report_mismatch("match_found", 64'(out_tdata[OUT_HIT_BIT]), 64'(rx_expected.hit));
        if (out_tdata[OUT_CNT_MSB:OUT_CNT_LSB] !== rx_expected.cnt)
          report_mismatch("match_count", 64'(out_tdata[OUT_CNT_MSB:OUT_CNT_LSB]),
                          64'(rx_expected.cnt));
        if (out_tdata[OUT_OVF_BIT] !== rx_expected.ovf)
          report_mismatch("pattern_overflow", 64'(out_tdata[OUT_OVF_BIT]),
                          64'(rx_expected.ovf));
        if (out_tdata[OUT_DATA_W-1:OUT_OVF_BIT+1] !== '0)
          report_mismatch("padding", 64'(out_tdata[OUT_DATA_W-1:OUT_OVF_BIT+1]), 64'd0);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[kmp_pattern_match_counter_top] ERROR");
    $finish;
  end

endmodule
